FILE: sv/bpht_pkg.sv
// Shared constants for the bucketed pointer hash table.
`default_nettype none

package bpht_pkg;

    localparam logic [31:0] HASH_SEED        = 32'h5675_6789;
    localparam logic [3:0]  TABLE_BITS_RESET = 4'd8;
    localparam int          MAX_RESULTS      = 8;
    localparam int          CNT_W            = $clog2(MAX_RESULTS);

    localparam logic [2:0] MODE_INSERT = 3'd0;
    localparam logic [2:0] MODE_REMOVE = 3'd1;
    localparam logic [2:0] MODE_LOOKUP = 3'd2;
    localparam logic [2:0] MODE_LIST   = 3'd3;
    localparam logic [2:0] MODE_CLEAR  = 3'd4;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_MISS = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

endpackage

`default_nettype wire

FILE: sv/bucketed_pointer_hash_table_core.sv
// Top level: hash sequencer, bucket fill memory and entry memory.
// Sequence: accept, hash the four key bytes, read the bucket fill count, then visit bucket entries;
//   the result shows in the first cycle with busy low (scans visit at least one entry). One command
//   runs at a time; the next start is taken once busy is low.
// Remove then moves later entries up a slot; a list that ends on a match or hits MAX_RESULTS
// matches adds a flush step. Clear command and reset both sweep the fill memory, busy high.
// Unused modes answer the cycle after accept without going busy. Results cannot be stalled.
`default_nettype none

module bucketed_pointer_hash_table_core #(
    parameter int MAX_TABLE_BITS = 8,
    parameter int BUCKET_DEPTH   = 8
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [2:0]  mode,
    input  wire logic [31:0] key,
    input  wire logic [31:0] item,
    input  wire logic        cfg_we,
    input  wire logic [3:0]  cfg_wdata,
    output logic             result_valid,
    output logic [1:0]       status,
    output logic [31:0]      item_out,
    output logic [7:0]       bucket_index,
    output logic             last
);

    localparam int NUM_BUCKETS = 1 << MAX_TABLE_BITS;
    localparam int ENTRY_DEPTH = NUM_BUCKETS * BUCKET_DEPTH;
    localparam int ADDR_W      = $clog2(ENTRY_DEPTH);
    localparam int FILL_W      = $clog2(BUCKET_DEPTH + 1);
    localparam int SLOT_W      = (BUCKET_DEPTH > 1) ? $clog2(BUCKET_DEPTH) : 1;
    localparam int CNT_W       = bpht_pkg::CNT_W;
    localparam logic [4:0] MTB5 = 5'(MAX_TABLE_BITS);

    typedef enum logic [2:0] {
        S_CLR,
        S_IDLE,
        S_HASH,
        S_FILLRD,
        S_SCAN,
        S_SHIFT,
        S_FLUSH
    } state_t;

    state_t                    state_reg, state_next;
    logic                      clr_cmd_reg, clr_cmd_next;
    logic [MAX_TABLE_BITS-1:0] clr_idx_reg, clr_idx_next;
    logic [3:0]                table_bits_reg, table_bits_next;
    logic [2:0]                mode_reg, mode_next;
    logic [31:0]               key_reg, key_next;
    logic [31:0]               item_reg, item_next;
    logic [31:0]               hc_reg, hc_next;
    logic [1:0]                byte_idx_reg, byte_idx_next;
    logic [MAX_TABLE_BITS-1:0] bucket_reg, bucket_next;
    logic [FILL_W-1:0]         idx_reg, idx_next;
    logic [CNT_W-1:0]          cnt_reg, cnt_next;
    logic                      pend_valid_reg, pend_valid_next;
    logic [31:0]               pend_item_reg, pend_item_next;
    logic                      result_valid_reg, result_valid_next;
    logic [1:0]                status_reg, status_next;
    logic [31:0]               item_out_reg, item_out_next;
    logic [7:0]                bucket_index_reg, bucket_index_next;
    logic                      last_reg, last_next;

    // memories and their read registers
    logic [63:0]       entry_mem [ENTRY_DEPTH];
    logic [FILL_W-1:0] fill_mem  [NUM_BUCKETS];
    logic [63:0]       entry_rd_reg;
    logic [FILL_W-1:0] fill_rd_reg;

    logic                      fill_re;
    logic                      fill_we;
    logic [MAX_TABLE_BITS-1:0] fill_waddr;
    logic [FILL_W-1:0]         fill_wdata;
    logic                      ent_we;
    logic [ADDR_W-1:0]         ent_waddr;
    logic [63:0]               ent_wdata;
    logic [ADDR_W-1:0]         ent_raddr;
    logic [ADDR_W-1:0]         base_addr;

    // hash unit
    logic [4:0]                bits_eff;
    logic [7:0]                hash_byte;
    logic [31:0]               hash_mix;
    logic [31:0]               hash_top;
    logic [31:0]               hash_out;
    logic [31:0]               hash_mask;
    logic [MAX_TABLE_BITS-1:0] hash_bucket;

    logic [FILL_W:0]   nxt_slot;
    logic [SLOT_W-1:0] rd_slot;
    logic              last_ent;
    logic              shift_done;
    logic              key_hit;
    logic              item_hit;

    always_comb
    begin
        if (table_bits_reg == 4'd0)
        begin
            bits_eff = 5'd1;
        end
        else if ({1'b0, table_bits_reg} > MTB5)
        begin
            bits_eff = MTB5;
        end
        else
        begin
            bits_eff = {1'b0, table_bits_reg};
        end
    end

    assign hash_byte   = 8'(key_reg >> {byte_idx_reg, 3'b000});
    assign hash_mix    = hc_reg ^ {{24{hash_byte[7]}}, hash_byte};
    assign hash_top    = hash_mix >> (6'd32 - {1'b0, bits_eff});
    assign hash_out    = (hash_mix << bits_eff[4:1]) ^ hash_top;
    assign hash_mask   = ~(32'hFFFF_FFFF << bits_eff);
    assign hash_bucket = MAX_TABLE_BITS'(hash_out & hash_mask);

    assign base_addr = ADDR_W'(bucket_reg) * ADDR_W'(BUCKET_DEPTH);

    // read one slot ahead of the entry being examined; two ahead while moving entries up
    always_comb
    begin
        unique case (state_reg)
            S_SCAN:  nxt_slot = {1'b0, idx_reg} + (FILL_W+1)'(1);
            S_SHIFT: nxt_slot = {1'b0, idx_reg} + (FILL_W+1)'(2);
            default: nxt_slot = '0;
        endcase
    end

    assign rd_slot    = (nxt_slot < (FILL_W+1)'(BUCKET_DEPTH)) ? nxt_slot[SLOT_W-1:0] : '0;
    assign ent_raddr  = base_addr + ADDR_W'(rd_slot);
    assign last_ent   = ({1'b0, idx_reg} + (FILL_W+1)'(1)) == {1'b0, fill_rd_reg};
    assign shift_done = nxt_slot == {1'b0, fill_rd_reg};
    assign key_hit    = entry_rd_reg[63:32] == key_reg;
    assign item_hit   = entry_rd_reg[31:0] == item_reg;
    assign fill_re    = state_reg == S_FILLRD;

    always_comb
    begin
        state_next        = state_reg;
        clr_cmd_next      = clr_cmd_reg;
        clr_idx_next      = clr_idx_reg;
        table_bits_next   = cfg_we ? cfg_wdata : table_bits_reg;
        mode_next         = mode_reg;
        key_next          = key_reg;
        item_next         = item_reg;
        hc_next           = hc_reg;
        byte_idx_next     = byte_idx_reg;
        bucket_next       = bucket_reg;
        idx_next          = idx_reg;
        cnt_next          = cnt_reg;
        pend_valid_next   = pend_valid_reg;
        pend_item_next    = pend_item_reg;
        result_valid_next = 1'b0;
        status_next       = status_reg;
        item_out_next     = item_out_reg;
        bucket_index_next = bucket_index_reg;
        last_next         = last_reg;
        fill_we           = 1'b0;
        fill_waddr        = bucket_reg;
        fill_wdata        = fill_rd_reg;
        ent_we            = 1'b0;
        ent_waddr         = base_addr + ADDR_W'(idx_reg[SLOT_W-1:0]);
        ent_wdata         = entry_rd_reg;

        unique case (state_reg)
            S_CLR:
            begin
                fill_we    = 1'b1;
                fill_waddr = clr_idx_reg;
                fill_wdata = '0;
                clr_idx_next = clr_idx_reg + MAX_TABLE_BITS'(1);
                if (clr_idx_reg == '1)
                begin
                    state_next = S_IDLE;
                    if (clr_cmd_reg)
                    begin
                        result_valid_next = 1'b1;
                        status_next       = bpht_pkg::ST_OK;
                        item_out_next     = '0;
                        bucket_index_next = '0;
                        last_next         = 1'b1;
                    end
                end
            end

            S_IDLE:
            begin
                if (start)
                begin
                    mode_next = mode;
                    key_next  = key;
                    item_next = item;
                    priority if (mode == bpht_pkg::MODE_CLEAR)
                    begin
                        clr_cmd_next = 1'b1;
                        clr_idx_next = '0;
                        state_next   = S_CLR;
                    end
                    else if (mode > bpht_pkg::MODE_CLEAR)
                    begin
                        result_valid_next = 1'b1;
                        status_next       = bpht_pkg::ST_MISS;
                        item_out_next     = '0;
                        bucket_index_next = '0;
                        last_next         = 1'b1;
                    end
                    else
                    begin
                        hc_next       = bpht_pkg::HASH_SEED << bits_eff;
                        byte_idx_next = '0;
                        state_next    = S_HASH;
                    end
                end
            end

            S_HASH:
            begin
                hc_next       = hash_out;
                byte_idx_next = byte_idx_reg + 2'd1;
                if (byte_idx_reg == 2'd3)
                begin
                    bucket_next = hash_bucket;
                    state_next  = S_FILLRD;
                end
            end

            S_FILLRD:
            begin
                idx_next        = '0;
                cnt_next        = '0;
                pend_valid_next = 1'b0;
                state_next      = S_SCAN;
            end

            S_SCAN:
            begin
                bucket_index_next = 8'(bucket_reg);
                item_out_next     = '0;
                last_next         = 1'b1;
                idx_next          = idx_reg + FILL_W'(1);
                if (mode_reg == bpht_pkg::MODE_INSERT)
                begin
                    result_valid_next = 1'b1;
                    state_next        = S_IDLE;
                    if (fill_rd_reg == FILL_W'(BUCKET_DEPTH))
                    begin
                        status_next = bpht_pkg::ST_FULL;
                    end
                    else
                    begin
                        status_next = bpht_pkg::ST_OK;
                        ent_we      = 1'b1;
                        ent_waddr   = base_addr + ADDR_W'(fill_rd_reg[SLOT_W-1:0]);
                        ent_wdata   = {key_reg, item_reg};
                        fill_we     = 1'b1;
                        fill_wdata  = fill_rd_reg + FILL_W'(1);
                    end
                end
                else if (fill_rd_reg == '0)
                begin
                    result_valid_next = 1'b1;
                    status_next       = bpht_pkg::ST_MISS;
                    state_next        = S_IDLE;
                end
                else
                begin
                    unique case (mode_reg)
                        bpht_pkg::MODE_REMOVE:
                        begin
                            if (key_hit && item_hit)
                            begin
                                fill_we    = 1'b1;
                                fill_wdata = fill_rd_reg - FILL_W'(1);
                                idx_next   = idx_reg;
                                if (last_ent)
                                begin
                                    result_valid_next = 1'b1;
                                    status_next       = bpht_pkg::ST_OK;
                                    state_next        = S_IDLE;
                                end
                                else
                                begin
                                    state_next = S_SHIFT;
                                end
                            end
                            else if (last_ent)
                            begin
                                result_valid_next = 1'b1;
                                status_next       = bpht_pkg::ST_MISS;
                                state_next        = S_IDLE;
                            end
                        end
                        bpht_pkg::MODE_LOOKUP:
                        begin
                            if (key_hit)
                            begin
                                result_valid_next = 1'b1;
                                status_next       = bpht_pkg::ST_OK;
                                item_out_next     = entry_rd_reg[31:0];
                                state_next        = S_IDLE;
                            end
                            else if (last_ent)
                            begin
                                result_valid_next = 1'b1;
                                status_next       = bpht_pkg::ST_MISS;
                                state_next        = S_IDLE;
                            end
                        end
                        default:
                        begin
                            // list: hold each match back one step so the final one can carry last
                            if (key_hit)
                            begin
                                if (pend_valid_reg)
                                begin
                                    result_valid_next = 1'b1;
                                    status_next       = bpht_pkg::ST_OK;
                                    item_out_next     = pend_item_reg;
                                    last_next         = 1'b0;
                                end
                                pend_valid_next = 1'b1;
                                pend_item_next  = entry_rd_reg[31:0];
                                cnt_next        = cnt_reg + CNT_W'(1);
                                if (last_ent ||
                                    cnt_reg == CNT_W'(bpht_pkg::MAX_RESULTS - 1))
                                begin
                                    state_next = S_FLUSH;
                                end
                            end
                            else if (last_ent)
                            begin
                                result_valid_next = 1'b1;
                                state_next        = S_IDLE;
                                if (pend_valid_reg)
                                begin
                                    status_next   = bpht_pkg::ST_OK;
                                    item_out_next = pend_item_reg;
                                end
                                else
                                begin
                                    status_next = bpht_pkg::ST_MISS;
                                end
                            end
                        end
                    endcase
                end
            end

            S_SHIFT:
            begin
                // entry_rd_reg holds slot idx+1; move it into slot idx
                ent_we    = 1'b1;
                ent_wdata = entry_rd_reg;
                idx_next  = idx_reg + FILL_W'(1);
                if (shift_done)
                begin
                    result_valid_next = 1'b1;
                    status_next       = bpht_pkg::ST_OK;
                    item_out_next     = '0;
                    bucket_index_next = 8'(bucket_reg);
                    last_next         = 1'b1;
                    state_next        = S_IDLE;
                end
            end

            S_FLUSH:
            begin
                result_valid_next = 1'b1;
                status_next       = bpht_pkg::ST_OK;
                item_out_next     = pend_item_reg;
                bucket_index_next = 8'(bucket_reg);
                last_next         = 1'b1;
                state_next        = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_CLR;
            clr_cmd_reg      <= 1'b0;
            clr_idx_reg      <= '0;
            table_bits_reg   <= bpht_pkg::TABLE_BITS_RESET;
            mode_reg         <= '0;
            key_reg          <= '0;
            item_reg         <= '0;
            hc_reg           <= '0;
            byte_idx_reg     <= '0;
            bucket_reg       <= '0;
            idx_reg          <= '0;
            cnt_reg          <= '0;
            pend_valid_reg   <= 1'b0;
            pend_item_reg    <= '0;
            result_valid_reg <= 1'b0;
            status_reg       <= '0;
            item_out_reg     <= '0;
            bucket_index_reg <= '0;
            last_reg         <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            clr_cmd_reg      <= clr_cmd_next;
            clr_idx_reg      <= clr_idx_next;
            table_bits_reg   <= table_bits_next;
            mode_reg         <= mode_next;
            key_reg          <= key_next;
            item_reg         <= item_next;
            hc_reg           <= hc_next;
            byte_idx_reg     <= byte_idx_next;
            bucket_reg       <= bucket_next;
            idx_reg          <= idx_next;
            cnt_reg          <= cnt_next;
            pend_valid_reg   <= pend_valid_next;
            pend_item_reg    <= pend_item_next;
            result_valid_reg <= result_valid_next;
            status_reg       <= status_next;
            item_out_reg     <= item_out_next;
            bucket_index_reg <= bucket_index_next;
            last_reg         <= last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fill_we)
        begin
            fill_mem[fill_waddr] <= fill_wdata;
        end
        if (fill_re)
        begin
            fill_rd_reg <= fill_mem[bucket_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ent_we)
        begin
            entry_mem[ent_waddr] <= ent_wdata;
        end
        entry_rd_reg <= entry_mem[ent_raddr];
    end

    assign busy         = state_reg != S_IDLE;
    assign result_valid = result_valid_reg;
    assign status       = status_reg;
    assign item_out     = item_out_reg;
    assign bucket_index = bucket_index_reg;
    assign last         = last_reg;

endmodule

`default_nettype wire

FILE: sv/bpht_checker.sv
// Port-level checks for the hash table core, bound to the top level.
`default_nettype none

module bpht_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        start,
    input wire logic        busy,
    input wire logic [2:0]  mode,
    input wire logic        result_valid,
    input wire logic [1:0]  status,
    input wire logic [31:0] item_out,
    input wire logic        last
);

    // every defined command keeps the block busy in the next cycle
    a_cmd_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && mode <= bpht_pkg::MODE_CLEAR) |=> busy)
        else $error("defined command did not raise busy");

    // misses and full buckets always end the command
    a_fail_last: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && status != bpht_pkg::ST_OK) |-> last)
        else $error("failing beat without last");

    // a beat that is not the final one leaves more work in flight
    a_more_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !last) |-> busy)
        else $error("non-final beat while idle");

    // a full bucket carries no item
    a_full_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && status == bpht_pkg::ST_FULL) |-> item_out == 32'd0)
        else $error("bucket full beat with nonzero item");

endmodule

bind bucketed_pointer_hash_table_core bpht_checker u_bpht_checker (.*);

`default_nettype wire

FILE: verif/tb_bucketed_pointer_hash_table_core.sv
// Self-checking testbench for the bucketed pointer hash table core.
`timescale 1ns / 1ps

module tb_bucketed_pointer_hash_table_core;

    localparam int NUM_BUCKETS = 256;
    localparam int DEPTH       = 8;
    localparam int CYCLE_LIMIT = 200000;

    localparam logic [2:0] MODE_RSVD5 = 3'd5;
    localparam logic [2:0] MODE_RSVD6 = 3'd6;
    localparam logic [2:0] MODE_RSVD7 = 3'd7;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] item_out;
        logic [7:0]  bucket;
        logic        last;
    } beat_t;

    class hash_table_scoreboard;
        logic [3:0]  fill [NUM_BUCKETS];
        logic [31:0] entry_key [NUM_BUCKETS * DEPTH];
        logic [31:0] entry_item [NUM_BUCKETS * DEPTH];
        logic [3:0]  table_bits;
        beat_t       expected_q[$];
        int          errors;

        function new();
            foreach (fill[i]) fill[i] = '0;
            table_bits = bpht_pkg::TABLE_BITS_RESET;
            errors = 0;
        endfunction

        function int unsigned active_bits();
            if (table_bits == 0) return 1;
            if (table_bits > 8) return 8;
            return table_bits;
        endfunction

        function logic [7:0] bucket_of(logic [31:0] k);
            logic [31:0] h;
            logic [31:0] top;
            logic [31:0] chunk;
            int unsigned bits;
            bits = active_bits();
            h = bpht_pkg::HASH_SEED << bits;
            for (int i = 0; i < 4; i++)
            begin
                chunk = {{24{k[8 * i + 7]}}, k[8 * i +: 8]};
                h = h ^ chunk;
                top = h >> (32 - bits);
                h = h << (bits / 2);
                h = h ^ top;
            end
            h = h & ((32'd1 << bits) - 32'd1);
            return h[7:0];
        endfunction

        function void push(logic [1:0] st, logic [31:0] v, logic [7:0] bkt, logic lst);
            beat_t b;
            b.status = st;
            b.item_out = v;
            b.bucket = bkt;
            b.last = lst;
            expected_q.push_back(b);
        endfunction

        // Predict every beat caused by one accepted command.
        function void note_command(logic [2:0] m, logic [31:0] k, logic [31:0] v);
            logic [7:0] bkt;
            int unsigned f;
            int unsigned base;
            int hit;
            int hits[$];
            if (m == bpht_pkg::MODE_CLEAR)
            begin
                foreach (fill[i]) fill[i] = '0;
                push(bpht_pkg::ST_OK, '0, '0, 1'b1);
                return;
            end
            if (m > bpht_pkg::MODE_CLEAR)
            begin
                push(bpht_pkg::ST_MISS, '0, '0, 1'b1);
                return;
            end
            bkt = bucket_of(k);
            f = fill[bkt];
            base = bkt * DEPTH;
            case (m)
                bpht_pkg::MODE_INSERT:
                begin
                    if (f >= DEPTH)
                        push(bpht_pkg::ST_FULL, '0, bkt, 1'b1);
                    else
                    begin
                        entry_key[base + f] = k;
                        entry_item[base + f] = v;
                        fill[bkt] = f + 1;
                        push(bpht_pkg::ST_OK, '0, bkt, 1'b1);
                    end
                end
                bpht_pkg::MODE_REMOVE:
                begin
                    hit = -1;
                    for (int i = 0; i < f; i++)
                        if (hit < 0 && entry_key[base + i] == k && entry_item[base + i] == v)
                            hit = i;
                    if (hit < 0)
                        push(bpht_pkg::ST_MISS, '0, bkt, 1'b1);
                    else
                    begin
                        for (int i = hit; i + 1 < f; i++)
                        begin
                            entry_key[base + i] = entry_key[base + i + 1];
                            entry_item[base + i] = entry_item[base + i + 1];
                        end
                        fill[bkt] = f - 1;
                        push(bpht_pkg::ST_OK, '0, bkt, 1'b1);
                    end
                end
                bpht_pkg::MODE_LOOKUP:
                begin
                    hit = -1;
                    for (int i = 0; i < f; i++)
                        if (hit < 0 && entry_key[base + i] == k)
                            hit = i;
                    if (hit < 0)
                        push(bpht_pkg::ST_MISS, '0, bkt, 1'b1);
                    else
                        push(bpht_pkg::ST_OK, entry_item[base + hit], bkt, 1'b1);
                end
                default:
                begin
                    for (int i = 0; i < f; i++)
                        if (hits.size() < bpht_pkg::MAX_RESULTS && entry_key[base + i] == k)
                            hits.push_back(i);
                    if (hits.size() == 0)
                        push(bpht_pkg::ST_MISS, '0, bkt, 1'b1);
                    else
                        foreach (hits[j])
                            push(bpht_pkg::ST_OK, entry_item[base + hits[j]], bkt,
                                 j == hits.size() - 1);
                end
            endcase
        endfunction

        function void report(string what, beat_t want, beat_t got);
            errors++;
            if (errors <= 10)
                $display("%t %s: expected status=%0d item=%h bucket=%0d last=%b",
                         $realtime, what, want.status, want.item_out, want.bucket, want.last,
                         ", got status=%0d item=%h bucket=%0d last=%b",
                         got.status, got.item_out, got.bucket, got.last);
        endfunction

        function void check_beat(beat_t got);
            beat_t want;
            if (expected_q.size() == 0)
            begin
                want = '0;
                report("unexpected result beat", want, got);
            end
            else
            begin
                want = expected_q.pop_front();
                if (got.status !== want.status || got.item_out !== want.item_out ||
                    got.bucket !== want.bucket || got.last !== want.last)
                    report("result beat differs", want, got);
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [2:0]  mode;
    logic [31:0] key;
    logic [31:0] item;
    logic        cfg_we;
    logic [3:0]  cfg_wdata;
    logic        result_valid;
    logic [1:0]  status;
    logic [31:0] item_out;
    logic [7:0]  bucket_index;
    logic        last;

    hash_table_scoreboard sb;
    int          cycle_count = 0;
    int          burst_left = 0;
    logic [31:0] key_pool [12];
    logic [31:0] item_pool [4];

    bucketed_pointer_hash_table_core #(
        .MAX_TABLE_BITS (8),
        .BUCKET_DEPTH   (DEPTH)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .mode         (mode),
        .key          (key),
        .item         (item),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .result_valid (result_valid),
        .status       (status),
        .item_out     (item_out),
        .bucket_index (bucket_index),
        .last         (last)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("bucketed_pointer_hash_table_core: mismatch");
            $finish;
        end
    end

    always @(posedge clk)
        if (rst_n === 1'b1 && result_valid === 1'b1)
            sb.check_beat({status, item_out, bucket_index, last});

    // Bursts of back-to-back commands separated by idle gaps.
    task automatic pace();
        int gap;
        if (burst_left == 0)
        begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(12, 30)
                                                     : $urandom_range(1, 6);
            gap = $urandom_range(1, 14);
            repeat (gap)
            begin
                @(negedge clk);
                start <= 1'b0;
            end
        end
        burst_left--;
    endtask

    task automatic send_cmd(input logic [2:0] m, input logic [31:0] k, input logic [31:0] v);
        pace();
        @(negedge clk);
        start <= 1'b1;
        mode <= m;
        key <= k;
        item <= v;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        sb.note_command(m, k, v);
    endtask

    task automatic drain();
        @(negedge clk);
        start <= 1'b0;
        while (sb.pending() != 0 || busy)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_table_bits(input logic [3:0] v);
        drain();
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(negedge clk);
        cfg_we <= 1'b0;
        sb.table_bits = v;
    endtask

    task automatic random_phase(input int count);
        int r;
        logic [2:0]  m;
        logic [31:0] k;
        logic [31:0] v;
        for (int n = 0; n < count; n++)
        begin
            r = $urandom_range(0, 99);
            k = ($urandom_range(0, 9) < 8) ? key_pool[$urandom_range(0, 11)] : $urandom;
            v = ($urandom_range(0, 9) < 7) ? item_pool[$urandom_range(0, 3)] : $urandom;
            if (r < 35)
                m = bpht_pkg::MODE_INSERT;
            else if (r < 55)
                m = bpht_pkg::MODE_REMOVE;
            else if (r < 72)
                m = bpht_pkg::MODE_LOOKUP;
            else if (r < 90)
                m = bpht_pkg::MODE_LIST;
            else if (r < 93)
                m = bpht_pkg::MODE_CLEAR;
            else
                m = MODE_RSVD5 + 3'($urandom_range(0, 2));
            send_cmd(m, k, v);
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        mode = bpht_pkg::MODE_INSERT;
        key = '0;
        item = '0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        sb = new();
        foreach (key_pool[i]) key_pool[i] = $urandom;
        foreach (item_pool[i]) item_pool[i] = $urandom;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: field extremes, misses, unused modes, clear
        send_cmd(bpht_pkg::MODE_LOOKUP, 32'h0000_0000, 32'h0);
        send_cmd(bpht_pkg::MODE_INSERT, 32'h0000_0000, 32'hFFFF_FFFF);
        send_cmd(bpht_pkg::MODE_INSERT, 32'hFFFF_FFFF, 32'h0000_0000);
        send_cmd(bpht_pkg::MODE_LOOKUP, 32'hFFFF_FFFF, 32'h0);
        send_cmd(bpht_pkg::MODE_LIST, 32'h0000_0000, 32'h0);
        send_cmd(bpht_pkg::MODE_REMOVE, 32'h0000_0000, 32'h0000_0000);
        send_cmd(bpht_pkg::MODE_REMOVE, 32'h0000_0000, 32'hFFFF_FFFF);
        send_cmd(MODE_RSVD5, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_cmd(MODE_RSVD6, 32'h8080_8080, 32'h1234_5678);
        send_cmd(MODE_RSVD7, 32'h7F7F_7F7F, 32'h0);
        send_cmd(bpht_pkg::MODE_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF);

        // zero table bits acts as one: fill a bucket past its depth
        write_table_bits(4'd0);
        for (int i = 0; i < DEPTH + 1; i++)
            send_cmd(bpht_pkg::MODE_INSERT, 32'h12F4_8056, 32'hA5A5_0000 + i);
        send_cmd(bpht_pkg::MODE_LIST, 32'h12F4_8056, 32'h0);
        send_cmd(bpht_pkg::MODE_REMOVE, 32'h12F4_8056, 32'hA5A5_0003);
        send_cmd(bpht_pkg::MODE_LIST, 32'h12F4_8056, 32'h0);

        // oversized table bits; old entries stay where they were
        write_table_bits(4'd15);
        send_cmd(bpht_pkg::MODE_LOOKUP, 32'h12F4_8056, 32'h0);

        write_table_bits(4'd1);
        random_phase(18);
        write_table_bits(4'd8);
        random_phase(18);
        write_table_bits(4'd3);
        random_phase(18);
        write_table_bits(4'd15);
        random_phase(18);
        write_table_bits(4'd0);
        random_phase(18);
        write_table_bits(4'($urandom_range(0, 15)));
        random_phase(18);

        drain();
        repeat (20) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("bucketed_pointer_hash_table_core: match");
        else
            $display("bucketed_pointer_hash_table_core: mismatch");
        $finish;
    end

endmodule
